// ===== rtl/assert_macros.svh =====
// assertion macros for the cell list binner
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, off while reset is high
`define PCLB_ASSERT(label, clock, reset, prop) \
  label: assert property (@(posedge clock) disable iff (reset) prop) \
    else $error("pclb assertion failed");

// same, on the usual clk and rst
`define PCLB_ASSERT_CLK(label, prop) `PCLB_ASSERT(label, clk, rst, prop)

`endif

// ===== rtl/pclb_pkg.sv =====
// shared types and constants for the cell list binner
package pclb_pkg;

  localparam int POS_W      = 32;
  localparam int ID_W       = 16;
  localparam int CELL_W     = 15;
  localparam int GRID_W     = 6;
  localparam int NUM_AXES   = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int CNT_W      = $clog2(POS_W + 1);
  localparam int TMP_W      = 2 * GRID_W + 1;
  localparam int LIN_W      = TMP_W + GRID_W;
  localparam int ENTRY_W    = ID_W + 1;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_X      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_Y      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_Z      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CELL_SIZE_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CELL_SIZE_Y = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CELL_SIZE_Z = 3'd5;

  localparam logic [GRID_W-1:0] GRID_RESET = 6'd1;
  localparam logic [POS_W-1:0]  SIZE_RESET = 32'h0001_0000;

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_READ   = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef logic [NUM_AXES-1:0][POS_W-1:0] axis_word_t;

  typedef struct packed {
    cmd_t              command;
    logic [POS_W-1:0]  pos_x;
    logic [POS_W-1:0]  pos_y;
    logic [POS_W-1:0]  pos_z;
    logic [ID_W-1:0]   particle_id;
    logic [CELL_W-1:0] query_cell;
  } item_t;

  typedef struct packed {
    logic [CELL_W-1:0] cell_index;
    logic [ID_W-1:0]   link;
    logic              link_valid;
    logic              out_of_range;
  } result_t;

endpackage

// ===== rtl/pclb_div.sv =====
// three-lane restoring divider, one quotient bit per cycle on every lane
module pclb_div
  import pclb_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  axis_word_t dividend,
  input  axis_word_t divisor,
  output logic       done,
  output axis_word_t quotient
);

  logic             running;
  logic [CNT_W-1:0] cnt;
  axis_word_t       rem;
  axis_word_t       quo;
  axis_word_t       dvs;

  logic [NUM_AXES-1:0][POS_W:0]   trial;
  logic [NUM_AXES-1:0][POS_W+1:0] diff;

  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      trial[a] = {rem[a], quo[a][POS_W-1]};
      diff[a]  = {1'b0, trial[a]} - {2'b00, dvs[a]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= running && !start && (cnt == CNT_W'(1));
      if (start) begin
        running <= 1'b1;
        cnt     <= CNT_W'(POS_W);
      end else if (running) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          running <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (running) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        if (!diff[a][POS_W+1]) begin
          rem[a] <= diff[a][POS_W-1:0];
          quo[a] <= {quo[a][POS_W-2:0], 1'b1};
        end else begin
          rem[a] <= trial[a][POS_W-1:0];
          quo[a] <= {quo[a][POS_W-2:0], 1'b0};
        end
      end
    end
  end

  assign quotient = quo;

endmodule

// ===== rtl/particle_cell_list_binner.sv =====
// top level of the 3d cell list binner
// Commands enter on start when busy is low; each gives one result beat on done,
// which the receiver must take in that cycle. An insert runs the three
// coordinate divisions side by side, one quotient bit per cycle, then clamp,
// two multiply-add steps for the linear index, a head table read and the
// write back. A read goes straight to the head table read, and an unused
// command straight to its result. A clear sweeps the head table one entry per
// cycle, all MAX_CELLS entries, before its result. After reset the same sweep
// runs with busy high and no result; configuration writes are taken at any
// time.
`include "assert_macros.svh"

module particle_cell_list_binner
  import pclb_pkg::*;
#(
  parameter int MAX_GRID  = 32,
  parameter int MAX_CELLS = 32768
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  item_t                 item,
  output logic                  done,
  output result_t               result,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int AW = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DIV,
    S_CLAMP,
    S_MUL1,
    S_MUL2,
    S_READ,
    S_OUT
  } state_t;

  state_t state;

  logic [NUM_AXES-1:0][GRID_W-1:0] grid;
  axis_word_t                      cell_size;

  logic [NUM_AXES-1:0][GRID_W-1:0] g_eff;
  logic [NUM_AXES-1:0][GRID_W-1:0] c_clamp;
  logic [NUM_AXES-1:0]             c_flag;

  logic              div_start;
  logic              div_done;
  axis_word_t        div_quo;
  axis_word_t        dividend;

  logic [AW-1:0]       clr_addr;
  logic                clr_last;
  logic                clr_report;
  cmd_t                cmd;
  logic [ID_W-1:0]     pid;
  logic [CELL_W-1:0]   qcell;
  logic [NUM_AXES-1:0][GRID_W-1:0] coord;
  logic                oor;
  logic [TMP_W-1:0]    tmp;
  logic [LIN_W-1:0]    lin;
  logic                in_range;
  logic [AW-1:0]       addr;
  logic                hit;
  logic [ID_W-1:0]     hit_link;

  logic [31:0]         key;
  logic [AW-1:0]       raddr;
  logic                mem_we;
  logic [AW-1:0]       waddr;
  logic [ENTRY_W-1:0]  wdata;
  logic [ENTRY_W-1:0]  rd_data;
  logic [ENTRY_W-1:0]  mem [MAX_CELLS];

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      grid      <= {NUM_AXES{GRID_RESET}};
      cell_size <= {NUM_AXES{SIZE_RESET}};
    end else if (cfg_write) begin
      case (cfg_addr)
        REG_GRID_X:      grid[0]      <= cfg_data[GRID_W-1:0];
        REG_GRID_Y:      grid[1]      <= cfg_data[GRID_W-1:0];
        REG_GRID_Z:      grid[2]      <= cfg_data[GRID_W-1:0];
        REG_CELL_SIZE_X: cell_size[0] <= cfg_data[POS_W-1:0];
        REG_CELL_SIZE_Y: cell_size[1] <= cfg_data[POS_W-1:0];
        REG_CELL_SIZE_Z: cell_size[2] <= cfg_data[POS_W-1:0];
        default: ;
      endcase
    end
  end

  // effective grid and clamp of the quotients
  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      if (grid[a] == '0) begin
        g_eff[a] = GRID_W'(1);
      end else if (32'(grid[a]) > MAX_GRID) begin
        g_eff[a] = GRID_W'(MAX_GRID);
      end else begin
        g_eff[a] = grid[a];
      end
      if (div_quo[a] >= POS_W'(g_eff[a])) begin
        c_clamp[a] = g_eff[a] - 1'b1;
        c_flag[a]  = 1'b1;
      end else begin
        c_clamp[a] = div_quo[a][GRID_W-1:0];
        c_flag[a]  = 1'b0;
      end
    end
  end

  assign busy      = (state != S_IDLE);
  assign div_start = start && (state == S_IDLE) && (item.command == CMD_INSERT);
  assign dividend  = {item.pos_z, item.pos_y, item.pos_x};

  pclb_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (cell_size),
    .done     (div_done),
    .quotient (div_quo)
  );

  // head table address selection
  assign key   = (cmd == CMD_INSERT) ? 32'(lin) : 32'(qcell);
  assign raddr = AW'(key);

  assign clr_last = (clr_addr == AW'(MAX_CELLS - 1));
  assign hit      = in_range && rd_data[ID_W];
  assign hit_link = hit ? rd_data[ID_W-1:0] : '0;

  always_comb begin
    if (state == S_CLEAR) begin
      mem_we = 1'b1;
      waddr  = clr_addr;
      wdata  = '0;
    end else begin
      mem_we = (state == S_OUT) && (cmd == CMD_INSERT) && in_range;
      waddr  = addr;
      wdata  = {1'b1, pid};
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    rd_data <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_addr   <= '0;
      clr_report <= 1'b0;
      done       <= 1'b0;
      result     <= '0;
      cmd        <= CMD_NONE;
      pid        <= '0;
      qcell      <= '0;
      coord      <= '0;
      oor        <= 1'b0;
      tmp        <= '0;
      lin        <= '0;
      in_range   <= 1'b0;
      addr       <= '0;
    end else begin
      done <= (state == S_OUT) || ((state == S_CLEAR) && clr_report && clr_last);
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_last ? '0 : clr_addr + 1'b1;
          if (clr_last) begin
            state <= S_IDLE;
            if (clr_report) begin
              result <= '0;
            end
          end
        end
        S_IDLE: begin
          if (start) begin
            cmd   <= item.command;
            pid   <= item.particle_id;
            qcell <= item.query_cell;
            case (item.command)
              CMD_CLEAR: begin
                clr_report <= 1'b1;
                state      <= S_CLEAR;
              end
              CMD_INSERT: state <= S_DIV;
              CMD_READ:   state <= S_READ;
              default:    state <= S_OUT;
            endcase
          end
        end
        S_DIV: begin
          if (div_done) begin
            state <= S_CLAMP;
          end
        end
        S_CLAMP: begin
          coord <= c_clamp;
          oor   <= |c_flag;
          state <= S_MUL1;
        end
        S_MUL1: begin
          tmp   <= TMP_W'(coord[2]) * TMP_W'(g_eff[1]) + TMP_W'(coord[1]);
          state <= S_MUL2;
        end
        S_MUL2: begin
          lin   <= LIN_W'(tmp) * LIN_W'(g_eff[0]) + LIN_W'(coord[0]);
          state <= S_READ;
        end
        S_READ: begin
          in_range <= (key < 32'(MAX_CELLS));
          addr     <= raddr;
          state    <= S_OUT;
        end
        S_OUT: begin
          case (cmd)
            CMD_INSERT: begin
              result <= '{cell_index: CELL_W'(lin), link: hit_link, link_valid: hit,
                          out_of_range: oor};
            end
            CMD_READ: begin
              result <= '{cell_index: qcell, link: hit_link, link_valid: hit,
                          out_of_range: 1'b0};
            end
            default: result <= '0;
          endcase
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `PCLB_ASSERT_CLK(a_done_when_idle, done |-> !busy)
  `PCLB_ASSERT_CLK(a_accept_goes_busy, (start && !busy) |=> busy)
  `PCLB_ASSERT_CLK(a_single_beat, done |=> !done)
  `PCLB_ASSERT_CLK(a_empty_link_zero, (done && !result.link_valid) |-> (result.link == '0))

endmodule
